### rtl/assert_macros.svh
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");

`endif

### rtl/swo_pkg.sv
`timescale 1ns / 1ps

package swo_pkg;

   localparam int WHEELS         = 4;
   localparam int ANGLE_W        = 16;
   localparam int ANGLE_BITS_DEF = 16;
   localparam int TRAVEL_W       = 16;
   localparam int SIN_W          = 16;
   localparam int FRAC_BITS      = 14;
   localparam int TERM_W         = 17;
   localparam int AVG_SHIFT      = 2;
   localparam int SUM_W          = TERM_W + AVG_SHIFT;
   localparam int STEP_W         = 16;
   localparam int POS_W          = 32;
   localparam int STAGES         = 4;
   localparam int QUARTER_SLOTS  = 32;

   localparam logic [ANGLE_W-1:0] QUARTER_ANGLE = 16'h4000;

   // Quarter-wave sine, Q1.14, 64 steps per half turn
   localparam logic [14:0] SINE_TAB [QUARTER_SLOTS+1] = '{
      15'd0,     15'd804,   15'd1606,  15'd2404,  15'd3196,  15'd3981,  15'd4756,
      15'd5520,  15'd6270,  15'd7005,  15'd7723,  15'd8423,  15'd9102,  15'd9760,
      15'd10394, 15'd11003, 15'd11585, 15'd12140, 15'd12665, 15'd13160, 15'd13623,
      15'd14053, 15'd14449, 15'd14811, 15'd15137, 15'd15426, 15'd15679, 15'd15893,
      15'd16069, 15'd16207, 15'd16305, 15'd16364, 15'd16384
   };

   typedef enum logic [1:0] {
      OP_UPDATE = 2'd0,
      OP_CLEAR  = 2'd1,
      OP_LOAD   = 2'd2
   } op_type;

   typedef struct packed {
      logic [1:0]                 op;
      logic [ANGLE_W-1:0]         heading;
      logic [ANGLE_W-1:0]         steer_angle_0;
      logic [ANGLE_W-1:0]         steer_angle_1;
      logic [ANGLE_W-1:0]         steer_angle_2;
      logic [ANGLE_W-1:0]         steer_angle_3;
      logic signed [TRAVEL_W-1:0] travel_0;
      logic signed [TRAVEL_W-1:0] travel_1;
      logic signed [TRAVEL_W-1:0] travel_2;
      logic signed [TRAVEL_W-1:0] travel_3;
      logic signed [POS_W-1:0]    load_x;
      logic signed [POS_W-1:0]    load_y;
   } req_type;

   typedef struct packed {
      logic signed [POS_W-1:0]  pos_x;
      logic signed [POS_W-1:0]  pos_y;
      logic signed [STEP_W-1:0] step_x;
      logic signed [STEP_W-1:0] step_y;
   } rsp_type;

   typedef struct packed {
      logic load_a;
      logic load_b;
      logic load_c;
   } lane_ctl_type;

   typedef struct packed {
      logic signed [TERM_W-1:0] x;
      logic signed [TERM_W-1:0] y;
   } lane_term_type;

   // Interpolated sine over one quarter, m in 0..16384
   function automatic logic [14:0] quarter_sin(input logic [14:0] m);
      logic [5:0]  idx;
      logic [8:0]  frac;
      logic [14:0] lo;
      logic [14:0] hi;
      logic [9:0]  diff;
      logic [18:0] prod;
      logic [14:0] res;
      idx  = m[14:9];
      frac = m[8:0];
      if (idx >= 6'(QUARTER_SLOTS)) begin
         res = SINE_TAB[QUARTER_SLOTS];
      end else begin
         lo   = SINE_TAB[idx];
         hi   = SINE_TAB[idx + 6'd1];
         diff = 10'(hi - lo);
         prod = {9'd0, diff} * {10'd0, frac} + 19'd256;
         res  = lo + 15'(prod >> 9);
      end
      return res;
   endfunction

   function automatic logic signed [SIN_W-1:0] bin_sin(input logic [ANGLE_W-1:0] a);
      logic [1:0]              q;
      logic [14:0]             m;
      logic signed [SIN_W-1:0] v;
      q = a[15:14];
      // odd quarters run backwards
      m = q[0] ? (15'd16384 - {1'b0, a[13:0]}) : {1'b0, a[13:0]};
      v = signed'({1'b0, quarter_sin(m)});
      return q[1] ? -v : v;
   endfunction

endpackage

### rtl/swo_lane.sv
`timescale 1ns / 1ps

module swo_lane import swo_pkg::*; #(
   parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
   input  logic                       clock,
   input  logic [ANGLE_W-1:0]         heading,
   input  logic [ANGLE_W-1:0]         steer,
   input  logic signed [TRAVEL_W-1:0] travel,
   input  lane_ctl_type               ctl,
   output lane_term_type              term
);

   localparam int ANG_SHIFT = ANGLE_W - ANGLE_BITS;

   logic [ANGLE_W-1:0]         rel_full;
   logic [ANGLE_BITS-1:0]      rel_in;
   logic [ANGLE_BITS-1:0]      rel_ff;
   logic signed [TRAVEL_W-1:0] travel_a_ff;
   logic signed [TRAVEL_W-1:0] travel_b_ff;
   logic [ANGLE_W-1:0]         angle;
   logic signed [SIN_W-1:0]    sin_in;
   logic signed [SIN_W-1:0]    cos_in;
   logic signed [SIN_W-1:0]    sin_ff;
   logic signed [SIN_W-1:0]    cos_ff;
   logic signed [31:0]         prod_x;
   logic signed [31:0]         prod_y;
   lane_term_type              term_in;
   lane_term_type              term_ff;

   assign rel_full = heading - steer;
   assign rel_in   = rel_full[ANGLE_W-1 -: ANGLE_BITS];

   assign angle  = ANGLE_W'(rel_ff) << ANG_SHIFT;
   assign sin_in = bin_sin(angle);
   assign cos_in = bin_sin(angle + QUARTER_ANGLE);

   assign prod_x    = sin_ff * travel_b_ff;
   assign prod_y    = cos_ff * travel_b_ff;
   // floor shift by the Q1.14 fraction
   assign term_in.x = prod_x[FRAC_BITS+TERM_W-1:FRAC_BITS];
   assign term_in.y = prod_y[FRAC_BITS+TERM_W-1:FRAC_BITS];

   always_ff @(posedge clock) begin
      if (ctl.load_a) begin
         rel_ff      <= rel_in;
         travel_a_ff <= travel;
      end
      if (ctl.load_b) begin
         sin_ff      <= sin_in;
         cos_ff      <= cos_in;
         travel_b_ff <= travel_a_ff;
      end
      if (ctl.load_c) begin
         term_ff <= term_in;
      end
   end

   assign term = term_ff;

endmodule

### rtl/swo_merge.sv
`timescale 1ns / 1ps

module swo_merge import swo_pkg::*; (
   input  logic                     clock,
   input  lane_term_type            terms [WHEELS],
   input  logic                     load,
   output logic signed [STEP_W-1:0] step_x,
   output logic signed [STEP_W-1:0] step_y
);

   logic signed [SUM_W-1:0]  sum_x;
   logic signed [SUM_W-1:0]  sum_cos;
   logic signed [SUM_W-1:0]  sum_y;
   logic signed [STEP_W-1:0] step_x_in;
   logic signed [STEP_W-1:0] step_y_in;
   logic signed [STEP_W-1:0] step_x_ff;
   logic signed [STEP_W-1:0] step_y_ff;

   function automatic logic signed [STEP_W-1:0] avg_sat(input logic signed [SUM_W-1:0] s);
      logic signed [SUM_W-AVG_SHIFT-1:0] avg;
      logic signed [STEP_W-1:0]          res;
      avg = s[SUM_W-1:AVG_SHIFT];
      if (avg[SUM_W-AVG_SHIFT-1] != avg[STEP_W-1]) begin
         res = avg[SUM_W-AVG_SHIFT-1] ? {1'b1, {(STEP_W-1){1'b0}}}
                                      : {1'b0, {(STEP_W-1){1'b1}}};
      end else begin
         res = avg[STEP_W-1:0];
      end
      return res;
   endfunction

   always_comb begin
      sum_x   = '0;
      sum_cos = '0;
      for (int w = 0; w < WHEELS; w++) begin
         sum_x   = sum_x + SUM_W'(terms[w].x);
         sum_cos = sum_cos + SUM_W'(terms[w].y);
      end
      sum_y     = -sum_cos;
      step_x_in = avg_sat(sum_x);
      step_y_in = avg_sat(sum_y);
   end

   always_ff @(posedge clock) begin
      if (load) begin
         step_x_ff <= step_x_in;
         step_y_ff <= step_y_in;
      end
   end

   assign step_x = step_x_ff;
   assign step_y = step_y_ff;

endmodule

### rtl/swerve_wheel_odometry.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Swerve wheel odometry: dead reckoning of robot position from wheel data.
// Request channel (req_valid / req_ready / req_data) carries op, gyro heading,
// four steering angles, four travel distances and the load values.
// Response channel (rsp_valid / rsp_ready / rsp_data) returns the position
// after the request and the averaged step; one response per request.
// A request passes the angle register (loaded at the accepting edge), then
// the sine lookup, multiply, wheel merge and position update registers
// before its response is valid.
// Throughput: one request per cycle unless stalled; the four wheel lanes
// work in parallel; only the single position add links consecutive requests.
// Reset (synchronous, active high) clears the position to zero and empties
// the pipeline. A stalled receiver holds the response; each stage keeps
// taking requests while it has a free slot, so up to five requests are in
// flight before req_ready drops.
module swerve_wheel_odometry import swo_pkg::*; #(
   parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   typedef struct packed {
      logic [1:0]              op;
      logic signed [POS_W-1:0] load_x;
      logic signed [POS_W-1:0] load_y;
   } side_type;

   logic [STAGES-1:0]          valid_ff;
   logic [STAGES-1:0]          stage_ready;
   side_type                   side_ff [STAGES];
   logic                       out_ready;
   logic                       out_load;
   logic                       rsp_valid_ff;

   logic [ANGLE_W-1:0]         steer_w  [WHEELS];
   logic signed [TRAVEL_W-1:0] travel_w [WHEELS];
   lane_term_type              terms    [WHEELS];
   lane_ctl_type               lane_ctl;

   logic signed [STEP_W-1:0]   merge_x;
   logic signed [STEP_W-1:0]   merge_y;
   logic signed [STEP_W-1:0]   step_x_in;
   logic signed [STEP_W-1:0]   step_y_in;
   logic signed [STEP_W-1:0]   step_x_ff;
   logic signed [STEP_W-1:0]   step_y_ff;
   logic signed [POS_W-1:0]    pos_x_in;
   logic signed [POS_W-1:0]    pos_y_in;
   logic signed [POS_W-1:0]    pos_x_ff;
   logic signed [POS_W-1:0]    pos_y_ff;

   function automatic logic signed [POS_W-1:0] sat_add(input logic signed [POS_W-1:0] a,
                                                       input logic signed [STEP_W-1:0] b);
      logic signed [POS_W:0]   s;
      logic signed [POS_W-1:0] res;
      s = (POS_W+1)'(a) + (POS_W+1)'(b);
      if (s[POS_W] != s[POS_W-1]) begin
         res = s[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
      end else begin
         res = s[POS_W-1:0];
      end
      return res;
   endfunction

   // stage handshake: a stage loads when empty or when its successor loads
   assign out_ready = !rsp_valid_ff || rsp_ready;
   assign out_load  = out_ready && valid_ff[STAGES-1];

   always_comb begin
      stage_ready[STAGES-1] = !valid_ff[STAGES-1] || out_ready;
      for (int k = STAGES - 2; k >= 0; k--) begin
         stage_ready[k] = !valid_ff[k] || stage_ready[k+1];
      end
   end

   assign req_ready = stage_ready[0];

   assign lane_ctl.load_a = stage_ready[0];
   assign lane_ctl.load_b = stage_ready[1];
   assign lane_ctl.load_c = stage_ready[2];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (stage_ready[0]) begin
            valid_ff[0] <= req_valid;
         end
         for (int k = 1; k < STAGES; k++) begin
            if (stage_ready[k]) begin
               valid_ff[k] <= valid_ff[k-1];
            end
         end
         if (out_ready) begin
            rsp_valid_ff <= valid_ff[STAGES-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (stage_ready[0]) begin
         side_ff[0] <= '{op: req_data.op, load_x: req_data.load_x, load_y: req_data.load_y};
      end
      for (int k = 1; k < STAGES; k++) begin
         if (stage_ready[k]) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   assign steer_w[0]  = req_data.steer_angle_0;
   assign steer_w[1]  = req_data.steer_angle_1;
   assign steer_w[2]  = req_data.steer_angle_2;
   assign steer_w[3]  = req_data.steer_angle_3;
   assign travel_w[0] = req_data.travel_0;
   assign travel_w[1] = req_data.travel_1;
   assign travel_w[2] = req_data.travel_2;
   assign travel_w[3] = req_data.travel_3;

   for (genvar w = 0; w < WHEELS; w++) begin : g_lane
      swo_lane #(
         .ANGLE_BITS(ANGLE_BITS)
      ) u_lane (
         .clock   (clock),
         .heading (req_data.heading),
         .steer   (steer_w[w]),
         .travel  (travel_w[w]),
         .ctl     (lane_ctl),
         .term    (terms[w])
      );
   end

   swo_merge u_merge (
      .clock  (clock),
      .terms  (terms),
      .load   (stage_ready[STAGES-1]),
      .step_x (merge_x),
      .step_y (merge_y)
   );

   always_comb begin
      step_x_in = merge_x;
      step_y_in = merge_y;
      case (side_ff[STAGES-1].op)
         OP_LOAD: begin
            pos_x_in  = side_ff[STAGES-1].load_x;
            pos_y_in  = side_ff[STAGES-1].load_y;
            step_x_in = '0;
            step_y_in = '0;
         end
         OP_CLEAR: begin
            pos_x_in = POS_W'(merge_x);
            pos_y_in = POS_W'(merge_y);
         end
         default: begin
            pos_x_in = sat_add(pos_x_ff, merge_x);
            pos_y_in = sat_add(pos_y_ff, merge_y);
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_x_ff <= '0;
         pos_y_ff <= '0;
      end else if (out_load) begin
         pos_x_ff <= pos_x_in;
         pos_y_ff <= pos_y_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         step_x_ff <= step_x_in;
         step_y_ff <= step_y_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_data.pos_x  = pos_x_ff;
   assign rsp_data.pos_y  = pos_y_ff;
   assign rsp_data.step_x = step_x_ff;
   assign rsp_data.step_y = step_y_ff;

   `ASSERT_NEXT(a_load_pos, clock, reset, out_load && side_ff[STAGES-1].op == OP_LOAD, rsp_data.pos_x == $past(side_ff[STAGES-1].load_x) && rsp_data.step_x == '0)
   `ASSERT_NEXT(a_clear_pos, clock, reset, out_load && side_ff[STAGES-1].op == OP_CLEAR, rsp_data.pos_y == POS_W'(rsp_data.step_y))
   `ASSERT_NEXT(a_no_wrap, clock, reset, out_load && side_ff[STAGES-1].op == OP_UPDATE && !pos_x_ff[POS_W-1] && !merge_x[STEP_W-1], !rsp_data.pos_x[POS_W-1])
   `ASSERT_NEXT(a_hold_last, clock, reset, valid_ff[STAGES-1] && !out_ready, valid_ff[STAGES-1] && rsp_valid)

endmodule

### tb/odometry_checker.sv
`timescale 1ns / 1ps

module odometry_checker import swo_pkg::*; #(
   parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_ready,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_ready,
   input  rsp_type rsp_data,
   output int      outstanding,
   output int      failures
);

   localparam logic [15:0] ANGLE_KEEP = 16'hFFFF << (16 - ANGLE_BITS);

   // quarter-wave sine, Q1.14
   localparam int SINE_Q14 [33] = '{
      0, 804, 1606, 2404, 3196, 3981, 4756, 5520, 6270, 7005, 7723,
      8423, 9102, 9760, 10394, 11003, 11585, 12140, 12665, 13160, 13623,
      14053, 14449, 14811, 15137, 15426, 15679, 15893, 16069, 16207, 16305,
      16364, 16384
   };

   logic signed [31:0] track_x;
   logic signed [31:0] track_y;
   rsp_type            expected_fixes [$];

   function automatic longint quarter_sine(input logic [14:0] m);
      int     idx;
      longint lo;
      longint hi;
      idx = int'(m[14:9]);
      if (idx >= 32) begin
         return longint'(SINE_Q14[32]);
      end
      lo = longint'(SINE_Q14[idx]);
      hi = longint'(SINE_Q14[idx + 1]);
      return lo + (((hi - lo) * longint'(m[8:0]) + 64'sd256) >>> 9);
   endfunction

   function automatic longint binary_sine(input logic [15:0] a);
      logic [14:0] m;
      longint      v;
      // second and fourth quarters mirror, lower half negates
      m = a[14] ? 15'(16384 - int'(a[13:0])) : {1'b0, a[13:0]};
      v = quarter_sine(m);
      return a[15] ? -v : v;
   endfunction

   function automatic longint saturate(input longint v, input longint lo, input longint hi);
      if (v > hi) begin
         return hi;
      end
      if (v < lo) begin
         return lo;
      end
      return v;
   endfunction

   function automatic rsp_type advance_odometry(input req_type r);
      rsp_type            fix;
      logic [15:0]        steer [4];
      logic signed [15:0] travel [4];
      logic [15:0]        rel;
      longint             s;
      longint             c;
      longint             trav;
      longint             sum_x;
      longint             sum_y;
      longint             step_x;
      longint             step_y;
      steer  = '{r.steer_angle_0, r.steer_angle_1, r.steer_angle_2, r.steer_angle_3};
      travel = '{r.travel_0, r.travel_1, r.travel_2, r.travel_3};
      sum_x  = 0;
      sum_y  = 0;
      step_x = 0;
      step_y = 0;
      if (r.op == OP_LOAD) begin
         track_x = r.load_x;
         track_y = r.load_y;
      end else begin
         if (r.op == OP_CLEAR) begin
            track_x = '0;
            track_y = '0;
         end
         for (int w = 0; w < WHEELS; w++) begin
            rel   = (r.heading - steer[w]) & ANGLE_KEEP;
            s     = binary_sine(rel);
            c     = binary_sine(rel + 16'h4000);
            trav  = longint'(travel[w]);
            sum_x += (s * trav) >>> 14;
            sum_y -= (c * trav) >>> 14;
         end
         step_x  = saturate(sum_x >>> 2, -64'sd32768, 64'sd32767);
         step_y  = saturate(sum_y >>> 2, -64'sd32768, 64'sd32767);
         track_x = 32'(saturate(longint'(track_x) + step_x, -64'sd2147483648, 64'sd2147483647));
         track_y = 32'(saturate(longint'(track_y) + step_y, -64'sd2147483648, 64'sd2147483647));
      end
      fix.pos_x  = track_x;
      fix.pos_y  = track_y;
      fix.step_x = step_x[15:0];
      fix.step_y = step_y[15:0];
      return fix;
   endfunction

   function automatic int field_mismatch(input string label, input logic signed [63:0] want,
         input logic signed [63:0] got);
      if (want === got) begin
         return 0;
      end
      $display("%0t: %s expected %0d, got %0d", $time, label, want, got);
      return 1;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      int      bad;
      bad = 0;
      if (reset) begin
         track_x = '0;
         track_y = '0;
         expected_fixes.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_fixes.size() == 0) begin
               $display("%0t: response with no request pending: pos_x %0d pos_y %0d step_x %0d step_y %0d",
                  $time, rsp_data.pos_x, rsp_data.pos_y, rsp_data.step_x, rsp_data.step_y);
               bad++;
            end else begin
               want = expected_fixes.pop_front();
               bad += field_mismatch("pos_x", want.pos_x, rsp_data.pos_x);
               bad += field_mismatch("pos_y", want.pos_y, rsp_data.pos_y);
               bad += field_mismatch("step_x", want.step_x, rsp_data.step_x);
               bad += field_mismatch("step_y", want.step_y, rsp_data.step_y);
            end
         end
         if (req_valid && req_ready) begin
            expected_fixes.push_back(advance_odometry(req_data));
         end
      end
      outstanding <= expected_fixes.size();
      failures    <= failures + bad;
   end

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps

module testbench import swo_pkg::*;;

   localparam int         RANDOM_REQUESTS = 550;
   localparam int         PHASE_LENGTH    = 55;
   localparam int         QUIET_LIMIT     = 2000;
   localparam logic [1:0] OP_SPARE        = 2'd3;
   localparam int         SEND_IDLE [4]   = '{0, 70, 0, 29};
   localparam int         RECV_STALL [4]  = '{0, 0, 70, 29};
   localparam logic [15:0] BOUNDARY_ANGLES [6] = '{
      16'h3FFF, 16'h4001, 16'h7FFF, 16'h8000, 16'hBFFF, 16'hFFFF
   };

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;
   int      outstanding;
   int      failures;
   int      send_idle_pct  = 0;
   int      recv_stall_pct = 0;
   int      quiet_cycles   = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   swerve_wheel_odometry i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   odometry_checker i_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .outstanding (outstanding),
      .failures    (failures)
   );

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // no handshake on either side up to QUIET_LIMIT means a hang
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
         $display("swerve_wheel_odometry: mismatch");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic req_type random_request();
      req_type r;
      int      pick;
      pick = $urandom_range(99);
      r.op = (pick < 70) ? OP_UPDATE : (pick < 80) ? OP_CLEAR : (pick < 92) ? OP_LOAD : OP_SPARE;
      r.heading       = 16'($urandom);
      r.steer_angle_0 = 16'($urandom);
      r.steer_angle_1 = 16'($urandom);
      r.steer_angle_2 = 16'($urandom);
      r.steer_angle_3 = 16'($urandom);
      // steer near a quarter boundary relative to the heading
      if ($urandom_range(3) == 0) begin
         r.steer_angle_0 = r.heading - 16'($urandom_range(3) << 14) + 16'($urandom_range(2)) - 16'd1;
         r.steer_angle_2 = r.heading - 16'($urandom_range(3) << 14);
      end
      r.travel_0 = 16'($urandom);
      r.travel_1 = 16'($urandom);
      r.travel_2 = 16'($urandom);
      r.travel_3 = 16'($urandom);
      if ($urandom_range(9) == 0) begin
         r.travel_0 = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
         r.travel_1 = r.travel_0;
         r.travel_2 = r.travel_0;
         r.travel_3 = r.travel_0;
      end else if ($urandom_range(4) == 0) begin
         r.travel_0 = 16'($urandom_range(15)) - 16'sd8;
         r.travel_1 = 16'($urandom_range(15)) - 16'sd8;
      end
      // loads near the rails let the position saturate
      case ($urandom_range(3))
         0: begin
            r.load_x = 32'sh7FFF_FFFF - 32'($urandom_range(65535));
            r.load_y = 32'sh8000_0000 + 32'($urandom_range(65535));
         end
         1: begin
            r.load_x = 32'sh8000_0000 + 32'($urandom_range(65535));
            r.load_y = 32'sh7FFF_FFFF - 32'($urandom_range(65535));
         end
         default: begin
            r.load_x = 32'($urandom);
            r.load_y = 32'($urandom);
         end
      endcase
      return r;
   endfunction

   function automatic req_type wheel_request(input logic [1:0] op, input logic [15:0] heading,
         input logic [15:0] steer, input logic signed [15:0] travel);
      req_type r;
      r               = random_request();
      r.op            = op;
      r.heading       = heading;
      r.steer_angle_0 = steer;
      r.steer_angle_1 = steer;
      r.steer_angle_2 = steer;
      r.steer_angle_3 = steer;
      r.travel_0      = travel;
      r.travel_1      = travel;
      r.travel_2      = travel;
      r.travel_3      = travel;
      return r;
   endfunction

   task automatic send_request(input req_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do begin
         @(posedge clock);
      end while (!req_ready);
   endtask

   task automatic drain_requests();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) begin
         @(posedge clock);
      end
   endtask

   initial begin
      req_type r;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_request(wheel_request(OP_UPDATE, 16'h0000, 16'h0000, 16'sd0));
      send_request(wheel_request(OP_UPDATE, 16'h0000, 16'h0000, 16'sh7FFF));
      // Y step overflow: four full negative travels straight ahead
      send_request(wheel_request(OP_UPDATE, 16'h0000, 16'h0000, 16'sh8000));
      // X step overflow
      send_request(wheel_request(OP_UPDATE, 16'hC000, 16'h0000, 16'sh8000));
      send_request(wheel_request(OP_UPDATE, 16'h4000, 16'h0000, 16'sh8000));
      send_request(wheel_request(OP_CLEAR, 16'h8000, 16'h0000, 16'sh7FFF));

      // position saturation both ways
      r = wheel_request(OP_LOAD, 16'h1234, 16'h4321, 16'sd77);
      r.load_x = 32'sh7FFF_FFFF;
      r.load_y = 32'sh8000_0000;
      send_request(r);
      r = wheel_request(OP_UPDATE, 16'h4000, 16'h0000, 16'sh7FFF);
      r.steer_angle_2 = 16'h4000;
      r.steer_angle_3 = 16'h4000;
      send_request(r);
      r = wheel_request(OP_LOAD, 16'h0000, 16'h0000, 16'sd0);
      r.load_x = 32'sh8000_0000;
      r.load_y = 32'sh7FFF_FFFF;
      send_request(r);
      r = wheel_request(OP_UPDATE, 16'hC000, 16'h0000, 16'sh7FFF);
      r.steer_angle_2 = 16'h4000;
      r.steer_angle_3 = 16'h4000;
      send_request(r);

      send_request(wheel_request(OP_SPARE, 16'h2000, 16'h0000, 16'sd1000));
      send_request(wheel_request(OP_UPDATE, 16'h0000, 16'hFFFF, 16'sh7FFF));
      send_request(wheel_request(OP_UPDATE, 16'hFFFF, 16'h0000, 16'sh8000));
      send_request(wheel_request(OP_UPDATE, 16'h1234, 16'h0000, -16'sd1));
      for (int k = 0; k < 6; k++) begin
         send_request(wheel_request(OP_UPDATE, BOUNDARY_ANGLES[k], 16'h0000, 16'($urandom)));
      end
      r = wheel_request(OP_LOAD, 16'h0000, 16'h0000, 16'sd0);
      r.load_x = 32'sd0;
      r.load_y = 32'sd0;
      send_request(r);
      send_request(wheel_request(OP_CLEAR, 16'($urandom), 16'($urandom), 16'sd0));

      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         send_idle_pct  = SEND_IDLE[(n / PHASE_LENGTH) % 4];
         recv_stall_pct = RECV_STALL[(n / PHASE_LENGTH) % 4];
         if (n == RANDOM_REQUESTS / 2) begin
            drain_requests();
         end
         send_request(random_request());
      end

      drain_requests();
      repeat (10) @(posedge clock);
      if (failures == 0) begin
         $display("swerve_wheel_odometry: match");
      end else begin
         $display("swerve_wheel_odometry: mismatch");
      end
      $finish;
   end

endmodule

### sim.f
+incdir+rtl
rtl/swo_pkg.sv
rtl/swo_lane.sv
rtl/swo_merge.sv
rtl/swerve_wheel_odometry.sv
tb/odometry_checker.sv
tb/testbench.sv
